[design/rle_lz_image_decoder_unit_assert.svh]
// ---------------------------------------------------------------------------
// rle_lz_image_decoder_unit assertion macros
// concurrent check macros, compiled away when NO_ASSERTIONS is set
// ---------------------------------------------------------------------------
`ifndef RLE_LZ_IMAGE_DECODER_UNIT_ASSERT_SVH
`define RLE_LZ_IMAGE_DECODER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// implication checked every clock outside reset
`define RLZD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// implication whose consequent is checked at the next clock
`define RLZD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RLZD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define RLZD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

[design/rlzd_pkg.sv]
// ---------------------------------------------------------------------------
// rlzd_pkg
// shared types and constants of the rle/lz image decoder
// ---------------------------------------------------------------------------
package rlzd_pkg;

    localparam int WINDOW_BYTES_DEF    = 16384;
    localparam int MAX_BLOCK_BYTES_DEF = 8;

    // command codes
    localparam logic [1:0] CMD_BYTE  = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_FRAME = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_UNSUP    = 2'd1;
    localparam logic [1:0] ST_REACH    = 2'd2;
    localparam logic [1:0] ST_REJECTED = 2'd3;

    // register indexes
    localparam logic [1:0] REG_PIXEL_SIZE   = 2'd0;
    localparam logic [1:0] REG_LINE_STRIDE  = 2'd1;
    localparam logic [1:0] REG_FRAME_LENGTH = 2'd2;

    localparam logic [2:0]  PIXEL_SIZE_RST   = 3'd3;
    localparam logic [12:0] LINE_STRIDE_RST  = 13'd3072;
    localparam logic [24:0] FRAME_LENGTH_RST = 25'd3145728;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data_byte;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_pending;
        logic       frame_done;
        logic [1:0] status;
    } out_word_t;

    typedef struct packed {
        logic [2:0]  pixel_size;
        logic [12:0] line_stride;
        logic [24:0] frame_length;
    } cfg_t;

    typedef enum logic [9:0] {
        PH_CTRL     = 10'b0000000001,
        PH_LIT      = 10'b0000000010,
        PH_EXT_LO   = 10'b0000000100,
        PH_BLK_CNT  = 10'b0000001000,
        PH_BLK_DATA = 10'b0000010000,
        PH_PREF_LO  = 10'b0000100000,
        PH_PREF_CNT = 10'b0001000000,
        PH_RUN      = 10'b0010000000,
        PH_COPY     = 10'b0100000000,
        PH_ERR      = 10'b1000000000
    } phase_t;

endpackage

[design/rlzd_ram.sv]
// ---------------------------------------------------------------------------
// rlzd_ram
// generic single write port ram with registered read
// ---------------------------------------------------------------------------
module rlzd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

[design/rlzd_queue.sv]
// ---------------------------------------------------------------------------
// rlzd_queue
// front end: two-entry word queue between the input channel and the core
// ---------------------------------------------------------------------------
module rlzd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rlzd_pkg::in_word_t in_word,
    output logic              q_valid,
    output rlzd_pkg::in_word_t q_word,
    input  logic              q_pop
);
    import rlzd_pkg::*;

    in_word_t   slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_word   = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // word storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_word;
        end
    end
endmodule

[design/rlzd_core.sv]
// ---------------------------------------------------------------------------
// rlzd_core
// back end: code parser, run/copy drain, history window and output register
// ---------------------------------------------------------------------------
module rlzd_core #(
    parameter int WINDOW_BYTES    = rlzd_pkg::WINDOW_BYTES_DEF,
    parameter int MAX_BLOCK_BYTES = rlzd_pkg::MAX_BLOCK_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rlzd_pkg::cfg_t     cfg,
    input  logic               q_valid,
    input  rlzd_pkg::in_word_t q_word,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output rlzd_pkg::out_word_t out_word
);
    import rlzd_pkg::*;

    localparam int AW   = $clog2(WINDOW_BYTES);
    localparam int DW   = ((AW > 15) ? AW : 15) + 1;
    localparam int BIW  = $clog2(MAX_BLOCK_BYTES);
    localparam int HALF = MAX_BLOCK_BYTES / 2;

    phase_t          phase_reg, phase_next;
    logic [7:0]      ctrl_reg, ctrl_next;
    logic [15:0]     rem_reg, rem_next;
    logic [14:0]     dist_reg, dist_next;
    logic [BIW-1:0]  bidx_reg, bidx_next;
    logic [3:0]      blen_reg, blen_next;
    logic [1:0]      err_reg, err_next;
    logic [24:0]     pc_reg, pc_next;
    logic [AW-1:0]   wp_reg, wp_next;
    logic            rd_pend_reg;
    logic            out_valid_reg;
    out_word_t       out_reg, out_next;
    logic [7:0]      blk_mem [MAX_BLOCK_BYTES];

    logic            adv, active, need_rd, issue, go;
    logic            emit, blk_we;
    logic [7:0]      emit_byte, b, c;
    logic [1:0]      sub;
    logic [3:0]      ps;
    logic [DW-1:0]   diff;
    logic [AW-1:0]   raddr;
    logic [7:0]      rdata;
    logic [14:0]     dchk;
    logic            bad;
    logic            rejected, done_n;
    logic [3:0]      bidx_inc;
    logic [11:0]     cnt12;
    logic [12:0]     d13;

    // handshake and window read scheduling
    always_comb
    begin
        adv     = !out_valid_reg || out_ready;
        active  = (q_word.command == CMD_BYTE || q_word.command == CMD_TICK)
                  && (pc_reg < cfg.frame_length) && (phase_reg != PH_ERR);
        need_rd = q_valid && active && q_word.command == CMD_TICK && phase_reg == PH_COPY;
        issue   = need_rd && !rd_pend_reg;
        go      = q_valid && adv && (!need_rd || rd_pend_reg);
        diff    = DW'(wp_reg) - DW'(dist_reg);
        if (diff[DW-1])
        begin
            diff = diff + DW'(WINDOW_BYTES);
        end
        raddr   = diff[AW-1:0];
    end

    assign q_pop = go;

    // effective pixel size
    always_comb
    begin
        if (cfg.pixel_size == 3'd0)
        begin
            ps = 4'd1;
        end
        else if (32'(cfg.pixel_size) > HALF)
        begin
            ps = 4'(HALF);
        end
        else
        begin
            ps = {1'b0, cfg.pixel_size};
        end
    end

    // parse and drain
    always_comb
    begin
        phase_next = phase_reg;
        ctrl_next  = ctrl_reg;
        rem_next   = rem_reg;
        dist_next  = dist_reg;
        bidx_next  = bidx_reg;
        blen_next  = blen_reg;
        err_next   = err_reg;
        emit       = 1'b0;
        emit_byte  = 8'd0;
        blk_we     = 1'b0;
        rejected   = 1'b0;
        dchk       = 15'd0;
        b          = q_word.data_byte;
        c          = ctrl_reg;
        sub        = ctrl_reg[5:4];
        bidx_inc   = 4'(bidx_reg) + 4'd1;
        cnt12      = {c[3:0], b};
        d13        = 13'(cnt12) + 13'd1;
        if (q_word.command == CMD_FRAME)
        begin
            phase_next = PH_CTRL;
            ctrl_next  = 8'd0;
            rem_next   = 16'd0;
            dist_next  = 15'd0;
            bidx_next  = '0;
            blen_next  = 4'd1;
            err_next   = ST_OK;
        end
        else if (active && q_word.command == CMD_BYTE)
        begin
            unique case (phase_reg)
                PH_CTRL:
                begin
                    ctrl_next = b;
                    unique case (b[7:6])
                        2'd0:
                        begin
                            rem_next   = 16'(b[5:0]) + 16'd1;
                            phase_next = PH_LIT;
                        end
                        2'd1:
                        begin
                            rem_next   = 16'(b[5:0]) + 16'd2;
                            blen_next  = 4'd1;
                            bidx_next  = '0;
                            phase_next = PH_BLK_DATA;
                        end
                        2'd2:
                        begin
                            phase_next = PH_EXT_LO;
                        end
                        default:
                        begin
                            if (b[5:4] == 2'd0)
                            begin
                                phase_next = PH_BLK_CNT;
                            end
                            else if (b[5:4] == 2'd3)
                            begin
                                err_next   = ST_UNSUP;
                                phase_next = PH_ERR;
                            end
                            else
                            begin
                                phase_next = PH_PREF_LO;
                            end
                        end
                    endcase
                end
                PH_LIT:
                begin
                    emit      = 1'b1;
                    emit_byte = b;
                    rem_next  = rem_reg - 16'd1;
                    if (rem_next == 16'd0)
                    begin
                        phase_next = PH_CTRL;
                    end
                end
                PH_EXT_LO:
                begin
                    if (sub == 2'd0)
                    begin
                        rem_next   = 16'(cnt12) + 16'd2;
                        blen_next  = 4'd1;
                        bidx_next  = '0;
                        phase_next = PH_BLK_DATA;
                    end
                    else
                    begin
                        rem_next   = 16'(cnt12) + 16'd1;
                        dchk       = 15'(cfg.line_stride) << (sub - 2'd1);
                        dist_next  = dchk;
                        phase_next = bad ? PH_ERR : PH_COPY;
                        err_next   = bad ? ST_REACH : err_reg;
                    end
                end
                PH_BLK_CNT:
                begin
                    blen_next  = c[3] ? 4'(ps << 1) : ps;
                    rem_next   = 16'((12'({c[2:0], 8'd0}) + 12'(b) + 12'd2) * blen_next);
                    bidx_next  = '0;
                    phase_next = PH_BLK_DATA;
                end
                PH_BLK_DATA:
                begin
                    blk_we = 1'b1;
                    if (bidx_inc >= blen_reg)
                    begin
                        bidx_next  = '0;
                        phase_next = PH_RUN;
                    end
                    else
                    begin
                        bidx_next = BIW'(bidx_inc);
                    end
                end
                PH_PREF_LO:
                begin
                    dist_next  = (sub == 2'd1) ? 15'(d13 * ps) : 15'(d13);
                    phase_next = PH_PREF_CNT;
                end
                PH_PREF_CNT:
                begin
                    rem_next   = 16'((9'(b) + 9'd1) * ((sub == 2'd1) ? ps : 4'd1));
                    dchk       = dist_reg;
                    phase_next = bad ? PH_ERR : PH_COPY;
                    err_next   = bad ? ST_REACH : err_reg;
                end
                PH_RUN, PH_COPY:
                begin
                    rejected = 1'b1;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
        else if (active && (phase_reg == PH_RUN || phase_reg == PH_COPY))
        begin
            emit = 1'b1;
            if (phase_reg == PH_RUN)
            begin
                emit_byte = blk_mem[bidx_reg];
                bidx_next = (bidx_inc >= blen_reg) ? '0 : BIW'(bidx_inc);
            end
            else
            begin
                emit_byte = rdata;
            end
            rem_next = rem_reg - 16'd1;
            if (rem_next == 16'd0)
            begin
                phase_next = PH_CTRL;
            end
        end
    end

    // reach check of a new copy distance
    assign bad = (dchk == 15'd0) || (DW'(dchk) > DW'(WINDOW_BYTES))
                 || (25'(dchk) > pc_reg);

    // byte count, write pointer and result word
    always_comb
    begin
        pc_next = pc_reg;
        wp_next = wp_reg;
        if (q_word.command == CMD_FRAME)
        begin
            pc_next = 25'd0;
            wp_next = '0;
        end
        else if (emit)
        begin
            pc_next = pc_reg + 25'd1;
            wp_next = (wp_reg == AW'(WINDOW_BYTES - 1)) ? '0 : wp_reg + AW'(1);
        end
        done_n               = pc_next >= cfg.frame_length;
        out_next.out_byte    = emit ? emit_byte : 8'd0;
        out_next.byte_valid  = emit;
        out_next.run_pending = !done_n && (phase_next == PH_RUN || phase_next == PH_COPY);
        out_next.frame_done  = done_n;
        out_next.status      = (err_next != ST_OK) ? err_next :
                               (rejected ? ST_REJECTED : ST_OK);
    end

    // history window
    rlzd_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_BYTES)
    ) u_window (
        .clk   (clk),
        .we    (go && emit),
        .waddr (wp_reg),
        .wdata (emit_byte),
        .re    (issue),
        .raddr (raddr),
        .rdata (rdata)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_CTRL;
            ctrl_reg      <= 8'd0;
            rem_reg       <= 16'd0;
            dist_reg      <= 15'd0;
            bidx_reg      <= '0;
            blen_reg      <= 4'd1;
            err_reg       <= ST_OK;
            pc_reg        <= 25'd0;
            wp_reg        <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (go)
            begin
                phase_reg <= phase_next;
                ctrl_reg  <= ctrl_next;
                rem_reg   <= rem_next;
                dist_reg  <= dist_next;
                bidx_reg  <= bidx_next;
                blen_reg  <= blen_next;
                err_reg   <= err_next;
                pc_reg    <= pc_next;
                wp_reg    <= wp_next;
            end
            if (go)
            begin
                rd_pend_reg <= 1'b0;
            end
            else if (issue)
            begin
                rd_pend_reg <= 1'b1;
            end
            if (go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result register and block bytes
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            out_reg <= out_next;
        end
        if (go && blk_we)
        begin
            blk_mem[bidx_reg] <= b;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;
endmodule

[design/rle_lz_image_decoder_unit.sv]
// ---------------------------------------------------------------------------
// rle_lz_image_decoder_unit
// byte-stream image decompressor: literals, runs, block runs, back-references
// ---------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid/cmd_ready/cmd_word) takes one word per command:
//   a compressed byte, a tick that drains one byte of a pending run or copy,
//   or a new-frame marker. Every word gives exactly one result word on the
//   pix channel (pix_valid/pix_ready/pix_word).
//   cfg_we/cfg_index/cfg_data write pixel size, line stride and frame length.
// Path: an accepted word is held in the queue, then its result is registered;
//   a copy tick also waits for the registered history window read.
// Throughput: one word per cycle while the pix side does not stall; a copy
//   tick is held until the registered read of the single history RAM returns.
// Reset: control state clears at once, decoding starts a fresh frame; the
//   history window is not cleared and needs no clearing pass.
// Stall: a two-word queue and the result register let the input keep
//   flowing while a result waits; when both fill, cmd_ready drops.
// ---------------------------------------------------------------------------
`include "rle_lz_image_decoder_unit_assert.svh"

module rle_lz_image_decoder_unit #(
    parameter int WINDOW_BYTES    = rlzd_pkg::WINDOW_BYTES_DEF,
    parameter int MAX_BLOCK_BYTES = rlzd_pkg::MAX_BLOCK_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  rlzd_pkg::in_word_t  cmd_word,
    output logic                pix_valid,
    input  logic                pix_ready,
    output rlzd_pkg::out_word_t pix_word,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [24:0]         cfg_data
);
    import rlzd_pkg::*;

    cfg_t     cfg_reg;
    logic     q_valid, q_pop;
    in_word_t q_word;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pixel_size   <= PIXEL_SIZE_RST;
            cfg_reg.line_stride  <= LINE_STRIDE_RST;
            cfg_reg.frame_length <= FRAME_LENGTH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PIXEL_SIZE:   cfg_reg.pixel_size   <= cfg_data[2:0];
                REG_LINE_STRIDE:  cfg_reg.line_stride  <= cfg_data[12:0];
                REG_FRAME_LENGTH: cfg_reg.frame_length <= cfg_data;
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // front end queue
    rlzd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd_valid),
        .in_ready (cmd_ready),
        .in_word  (cmd_word),
        .q_valid  (q_valid),
        .q_word   (q_word),
        .q_pop    (q_pop)
    );

    // back end decoder
    rlzd_core #(
        .WINDOW_BYTES    (WINDOW_BYTES),
        .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_word    (q_word),
        .q_pop     (q_pop),
        .out_valid (pix_valid),
        .out_ready (pix_ready),
        .out_word  (pix_word)
    );

    // result consistency checks
    `RLZD_ASSERT_IMP(a_byte_ok, clk, rst_n, pix_valid && pix_word.byte_valid, pix_word.status == ST_OK, "byte emitted with nonzero status")
    `RLZD_ASSERT_IMP(a_done_idle, clk, rst_n, pix_valid && pix_word.frame_done, !pix_word.run_pending, "run pending after frame done")
    `RLZD_ASSERT_IMP(a_zero_byte, clk, rst_n, pix_valid && !pix_word.byte_valid, pix_word.out_byte == 8'd0, "out_byte nonzero without byte")
endmodule
